[rtl/wmsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wmsa_pkg;

  localparam int unsigned DeltaW   = 32;
  localparam int unsigned CoeffW   = 32;
  localparam int unsigned GapW     = 48;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned GainW    = 8;
  localparam int unsigned ScoreW   = 48;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned ScaledW  = WeightW + GainW;
  localparam int unsigned ContribW = ScaledW + 1;
  localparam int unsigned InDataW  = DeltaW + CoeffW + GapW + WeightW;
  localparam int unsigned OutDataW = ((ScoreW + 7) / 8) * 8;
  localparam int unsigned AddrW    = 3;

  localparam logic RegFeasible = 1'b0;
  localparam logic RegGain     = 1'b1;

  localparam logic [GainW-1:0] GainReset = 8'd1;

  typedef struct packed {
    logic                       valid;
    logic                       last;
    logic signed [ContribW-1:0] contrib;
  } term_t;

  typedef struct packed {
    logic s1_last;
    logic s2_last;
  } pipe_status_t;

endpackage

`default_nettype wire

[rtl/wmsa_term.sv]
`timescale 1ns / 1ps
`default_nettype none

module wmsa_term (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  input  wire signed [wmsa_pkg::DeltaW-1:0]     delta_i,
  input  wire signed [wmsa_pkg::CoeffW-1:0]     coeff_i,
  input  wire signed [wmsa_pkg::GapW-1:0]       gap_i,
  input  wire        [wmsa_pkg::WeightW-1:0]    weight_i,
  input  wire                                   obj_i,
  input  wire                                   last_i,
  input  wire                                   feasible_i,
  input  wire        [wmsa_pkg::GainW-1:0]      gain_i,
  output wmsa_pkg::term_t                       term_o,
  output wmsa_pkg::pipe_status_t                status_o
);

  // stage 1: products
  logic                                 s1_valid_q, s1_last_q, s1_obj_q;
  logic signed [wmsa_pkg::ProdW-1:0]    prod_d, prod_q;
  logic        [wmsa_pkg::ScaledW-1:0]  scaled_d, scaled_q;
  logic signed [wmsa_pkg::GapW-1:0]     gap_q;
  logic        [wmsa_pkg::WeightW-1:0]  weight_q;

  assign prod_d   = coeff_i * delta_i;
  assign scaled_d = {{wmsa_pkg::GainW{1'b0}}, weight_i}
                  * {{wmsa_pkg::WeightW{1'b0}}, gain_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s1_last_q  <= in_valid_i & last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    scaled_q <= scaled_d;
    gap_q    <= gap_i;
    weight_q <= weight_i;
    s1_obj_q <= obj_i;
  end

  // stage 2: new gap and contribution
  logic signed [wmsa_pkg::ProdW-1:0]    new_gap;
  logic                                 pre_sat, now_sat, shrank;
  logic signed [wmsa_pkg::ContribW-1:0] w_s, sc_s, contrib_d;
  logic                                 term_valid_q, term_last_q;
  logic signed [wmsa_pkg::ContribW-1:0] contrib_q;

  assign new_gap = wmsa_pkg::ProdW'(gap_q) + prod_q;
  assign pre_sat = gap_q[wmsa_pkg::GapW-1] | (gap_q == '0);
  assign now_sat = new_gap[wmsa_pkg::ProdW-1] | (new_gap == '0);
  assign shrank  = prod_q[wmsa_pkg::ProdW-1];
  assign w_s     = signed'({{(wmsa_pkg::ContribW - wmsa_pkg::WeightW){1'b0}}, weight_q});
  assign sc_s    = signed'({1'b0, scaled_q});

  always_comb begin
    contrib_d = '0;
    if (s1_obj_q) begin
      if (feasible_i) begin
        contrib_d = now_sat ? w_s : -w_s;
      end
    end else if (!pre_sat && now_sat) begin
      contrib_d = w_s;
    end else if (pre_sat && !now_sat) begin
      contrib_d = -w_s;
    end else if (!pre_sat && !now_sat) begin
      contrib_d = shrank ? sc_s : -sc_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_valid_q <= 1'b0;
      term_last_q  <= 1'b0;
    end else begin
      term_valid_q <= s1_valid_q;
      term_last_q  <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    contrib_q <= contrib_d;
  end

  assign term_o           = wmsa_pkg::term_t'{valid:   term_valid_q,
                                              last:    term_last_q,
                                              contrib: contrib_q};
  assign status_o.s1_last = s1_last_q;
  assign status_o.s2_last = term_last_q;

  a_last_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_last_q |-> term_valid_q)
    else $error("last mark without valid term");

  a_stage_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> term_valid_q)
    else $error("term dropped between stages");

  a_obj_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_obj_q && !feasible_i) |=> (contrib_q == '0))
    else $error("objective term scored while not feasible");

endmodule

`default_nettype wire

[rtl/wmsa_accum.sv]
`timescale 1ns / 1ps
`default_nettype none

module wmsa_accum (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wmsa_pkg::term_t                      term_i,
  output logic                                 push_o,
  output logic signed [wmsa_pkg::ScoreW-1:0]   push_data_o
);

  localparam int unsigned WideW = wmsa_pkg::ScoreW + 1;

  logic signed [wmsa_pkg::ScoreW-1:0] sum_q, sum_d, sat_sum;
  logic signed [WideW-1:0]            wide_sum;

  assign wide_sum = WideW'(sum_q) + WideW'(term_i.contrib);

  always_comb begin
    sat_sum = wide_sum[wmsa_pkg::ScoreW-1:0];
    if (wide_sum[WideW-1] != wide_sum[WideW-2]) begin
      sat_sum = wide_sum[WideW-1]
              ? {1'b1, {(wmsa_pkg::ScoreW-1){1'b0}}}
              : {1'b0, {(wmsa_pkg::ScoreW-1){1'b1}}};
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (term_i.valid) begin
      sum_d = term_i.last ? '0 : sat_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign push_o      = term_i.valid & term_i.last;
  assign push_data_o = sat_sum;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (sum_q == '0))
    else $error("score not cleared after last term");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !term_i.valid |=> (sum_q == $past(sum_q)))
    else $error("score moved without a term");

  a_sat_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (term_i.valid && term_i.contrib >= 0 && sum_q >= 0) |-> (sat_sum >= sum_q))
    else $error("positive term wrapped the score");

endmodule

`default_nettype wire

[rtl/wmsa_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module wmsa_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 48,
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [Width-1:0] push_data_i,
  output logic             valid_o,
  input  wire              ready_i,
  output logic [Width-1:0] data_o,
  output logic [CntW-1:0]  cnt_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             pop;

  assign pop = valid_o & ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |-> (cnt_q < CntW'(Depth)))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(rd_ptr_q)))
    else $error("stalled result moved");

endmodule

`default_nettype wire

[rtl/weighted_move_score_accumulator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Scores a candidate variable move from a stream of its row terms.
// Input beat: one term (delta, coefficient, row gap, row weight), tuser marks
// the objective row, tlast marks the final term of the move. Each term adds a
// signed contribution to a saturating 48-bit score; the final term releases
// the score on the master side as one beat and clears it.
// Configuration over APB: feasible_found at 0x0, violated_gain at 0x4.
// Throughput: one term per cycle while s_axis_tready is high. Terms pass an
// input register, a multiply stage and a gap/contribution stage; the
// accumulator adds the last term as its score enters the result queue, and
// the score beat is presented from the queue's registered output.
// Results wait in a queue of ResultDepth beats (at least 5 keeps terms
// flowing back to back while the receiver keeps up). The slave side takes
// terms while the queue has room for every move end still in flight; a
// stalled receiver backs up the queue and only then drops s_axis_tready.
// Reset clears the score, the queue and the pipeline, sets feasible_found
// to 0 and violated_gain to 1.
module weighted_move_score_accumulator #(
  parameter int unsigned ResultDepth = 8
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // move_delta[31:0], coeff[63:32], row_gap[111:64], row_weight[127:112]
  input  wire  [wmsa_pkg::InDataW-1:0]       s_axis_tdata,
  // is_objective[0]
  input  wire  [0:0]                         s_axis_tuser,
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // move_score[47:0]
  output logic [wmsa_pkg::OutDataW-1:0]      m_axis_tdata,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [wmsa_pkg::AddrW-1:0]         paddr,
  input  wire  [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned CntW = $clog2(ResultDepth + 1);
  localparam int unsigned SumW = CntW + 1;

  // configuration
  logic                             feasible_q;
  logic [wmsa_pkg::GainW-1:0]       gain_q;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feasible_q <= 1'b0;
      gain_q     <= wmsa_pkg::GainReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        wmsa_pkg::RegFeasible: feasible_q <= pwdata[0];
        wmsa_pkg::RegGain:     gain_q     <= pwdata[wmsa_pkg::GainW-1:0];
        default:               feasible_q <= feasible_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      wmsa_pkg::RegFeasible: prdata = {31'd0, feasible_q};
      wmsa_pkg::RegGain:     prdata = {{(32 - wmsa_pkg::GainW){1'b0}}, gain_q};
      default:               prdata = '0;
    endcase
  end

  // input register
  logic                                 s0_valid_q, s0_last_q, s0_obj_q;
  logic signed [wmsa_pkg::DeltaW-1:0]   s0_delta_q;
  logic signed [wmsa_pkg::CoeffW-1:0]   s0_coeff_q;
  logic signed [wmsa_pkg::GapW-1:0]     s0_gap_q;
  logic        [wmsa_pkg::WeightW-1:0]  s0_weight_q;
  logic                                 in_beat;

  assign in_beat = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s0_last_q  <= 1'b0;
    end else begin
      s0_valid_q <= in_beat;
      s0_last_q  <= in_beat & s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_delta_q  <= s_axis_tdata[31:0];
    s0_coeff_q  <= s_axis_tdata[63:32];
    s0_gap_q    <= s_axis_tdata[111:64];
    s0_weight_q <= s_axis_tdata[127:112];
    s0_obj_q    <= s_axis_tuser[0];
  end

  wmsa_pkg::term_t        term;
  wmsa_pkg::pipe_status_t status;

  wmsa_term u_term (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s0_valid_q),
    .delta_i    (s0_delta_q),
    .coeff_i    (s0_coeff_q),
    .gap_i      (s0_gap_q),
    .weight_i   (s0_weight_q),
    .obj_i      (s0_obj_q),
    .last_i     (s0_last_q),
    .feasible_i (feasible_q),
    .gain_i     (gain_q),
    .term_o     (term),
    .status_o   (status)
  );

  logic                                push;
  logic signed [wmsa_pkg::ScoreW-1:0]  push_data;

  wmsa_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .term_i      (term),
    .push_o      (push),
    .push_data_o (push_data)
  );

  logic [wmsa_pkg::ScoreW-1:0] q_data;
  logic [CntW-1:0]             q_cnt;

  wmsa_fifo #(
    .Depth (ResultDepth),
    .Width (wmsa_pkg::ScoreW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (q_data),
    .cnt_o       (q_cnt)
  );

  assign m_axis_tdata = {{(wmsa_pkg::OutDataW - wmsa_pkg::ScoreW){1'b0}}, q_data};

  // reserve a queue slot for every move end in flight
  logic [SumW-1:0] committed;

  assign committed = SumW'(q_cnt) + SumW'(s0_last_q) + SumW'(status.s1_last)
                   + SumW'(status.s2_last);
  assign s_axis_tready = (committed < SumW'(ResultDepth));

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed <= SumW'(ResultDepth))
    else $error("more results in flight than queue slots");

  a_last_reaches_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_last_q |-> ##2 push)
    else $error("move end did not reach the result queue");

  a_cfg_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[2] == wmsa_pkg::RegGain) |=> (gain_q == $past(pwdata[7:0])))
    else $error("gain register write lost");

endmodule

`default_nettype wire
